### hw/rtl/fpdsp_pkg.sv
`timescale 1ns / 1ps
package fpdsp_pkg;

  localparam int DataRamDepth = 2048;
  localparam int StackDepth   = 16;

  typedef enum logic [2:0] {
    CMD_EXEC     = 3'd0,
    CMD_STATUS   = 3'd1,
    CMD_DATA_RD  = 3'd2,
    CMD_DATA_WR  = 3'd3,
    CMD_RAM_RD   = 3'd4,
    CMD_RAM_WR   = 3'd5,
    CMD_RSVD6    = 3'd6,
    CMD_RSVD7    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_OP  = 2'd0,
    KIND_RT  = 2'd1,
    KIND_JP  = 2'd2,
    KIND_LD  = 2'd3
  } kind_t;

  localparam logic [15:0] SR_RQM  = 16'h8000;
  localparam logic [15:0] SR_DRS  = 16'h1000;
  localparam logic [15:0] SR_DRC  = 16'h0400;
  localparam logic [15:0] SR_BITS = 16'hff83;
  localparam logic [15:0] SR_KEEP = 16'h907c;

  localparam logic [8:0] BR_SO    = 9'h000;
  localparam logic [8:0] BR_DPL0  = 9'h0b0;
  localparam logic [8:0] BR_DPLN0 = 9'h0b1;
  localparam logic [8:0] BR_DPLF  = 9'h0b2;
  localparam logic [8:0] BR_DPLNF = 9'h0b3;
  localparam logic [8:0] BR_NRQM  = 9'h0bc;
  localparam logic [8:0] BR_RQM   = 9'h0be;
  localparam logic [8:0] BR_JMP0  = 9'h100;
  localparam logic [8:0] BR_JMP1  = 9'h101;
  localparam logic [8:0] BR_CALL0 = 9'h140;
  localparam logic [8:0] BR_CALL1 = 9'h141;

  // flag bit positions
  localparam int F_S1 = 5;
  localparam int F_S0 = 4;
  localparam int F_C  = 3;
  localparam int F_Z  = 2;
  localparam int F_OV1 = 1;
  localparam int F_OV0 = 0;

  typedef struct packed {
    logic [2:0]  command;
    logic [23:0] instruction;
    logic [15:0] rom_word;
    logic [7:0]  bus_byte;
    logic [11:0] ram_byte_address;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [13:0] next_pc;
    logic [10:0] rom_pointer;
    logic        waiting_for_host;
  } out_word_t;

  // RAM access request from the core to the RAM unit
  typedef struct packed {
    logic        we;
    logic [10:0] waddr;
    logic [15:0] wdata;
  } ram_wr_t;

endpackage

### hw/rtl/fpdsp_ram.sv
`timescale 1ns / 1ps
module fpdsp_ram import fpdsp_pkg::*; #(
  parameter int Depth = DataRamDepth
) (
  input  logic                     clk,
  input  ram_wr_t                  wr,
  input  logic [$clog2(Depth)-1:0] ra0,
  input  logic [$clog2(Depth)-1:0] ra1,
  output logic [15:0]              rd0,
  output logic [15:0]              rd1
);
  logic [15:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr[$clog2(Depth)-1:0]] <= wr.wdata;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end
endmodule

### hw/rtl/fixed_point_dsp_instruction_core.sv
`timescale 1ns / 1ps
// Path: input register and RAM read, then execute into the output register.
// Throughput: one word per cycle while out_ready does not stall the output.
// Reset: rst_n synchronous, active low; clears all architectural registers.
// Data RAM content is not cleared; reads of unwritten entries are undefined.
module fixed_point_dsp_instruction_core import fpdsp_pkg::*; #(
  parameter int DATA_RAM_DEPTH = DataRamDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  localparam int AW = $clog2(DATA_RAM_DEPTH);

  logic        rev_r;
  logic        s1_valid_r;
  in_word_t    s1_r;
  logic        out_valid_r;
  out_word_t   out_r;
  logic        advance;

  logic [13:0] pc_r;
  logic [13:0] stk_r [StackDepth];
  logic [3:0]  sp_r;
  logic [10:0] dp_r, rp_r;
  logic [15:0] acca_r, accb_r, k_r, l_r, m_r, n_r, tr_r, trb_r, sr_r, dr_r, so_r;
  logic [5:0]  fla_r, flb_r;

  // Writes land on edge; a read issued in the same cycle needs the fresh value.
  ram_wr_t     wr, wr_r;
  logic [15:0] rd0_raw, rd1_raw, rd0, rd1;
  logic [AW-1:0] ra0_q, ra1_q;
  logic [AW-1:0] ra0, ra1;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r <= 1'b0;
    end else if (cfg_we) begin
      rev_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) s1_r <= in_data;
  end

  // Read addresses come from the incoming word and the state after the
  // word executing now. Execution only needs ram[dp], ram[dp|0x40] and the
  // host byte address; we look up from registered state, so read here and
  // bypass the executing word's write.
  in_word_t    nx;
  logic [10:0] dp_nxt;
  assign nx = (in_valid && in_ready) ? in_data : s1_r;

  always_comb begin
    if (nx.command == CMD_EXEC) begin
      ra0 = dp_nxt[AW-1:0];
      ra1 = AW'(dp_nxt | 11'h040);
    end else begin
      ra0 = nx.ram_byte_address[AW:1];
      ra1 = nx.ram_byte_address[AW:1];
    end
  end

  fpdsp_ram #(.Depth(DATA_RAM_DEPTH)) u_ram (
    .clk(clk), .wr(wr), .ra0(ra0), .ra1(ra1), .rd0(rd0_raw), .rd1(rd1_raw)
  );

  always_ff @(posedge clk) begin
    ra0_q <= ra0;
    ra1_q <= ra1;
    wr_r  <= wr;
  end

  assign rd0 = (wr_r.we && wr_r.waddr[AW-1:0] == ra0_q) ? wr_r.wdata : rd0_raw;
  assign rd1 = (wr_r.we && wr_r.waddr[AW-1:0] == ra1_q) ? wr_r.wdata : rd1_raw;

  // ---------------- execute ----------------
  logic [13:0] pc_nxt;
  logic [13:0] pc_inc;
  logic [3:0]  sp_nxt;
  logic [10:0] rp_nxt;
  logic [15:0] acca_nxt, accb_nxt, k_nxt, l_nxt, tr_nxt, trb_nxt, sr_nxt, dr_nxt, so_nxt;
  logic [5:0]  fla_nxt, flb_nxt;
  logic        stk_we;
  logic [7:0]  rd_byte;
  logic        wait_f;

  logic [23:0] op;
  kind_t       kind;
  logic [13:0] pcm;
  logic [10:0] dpm, rpm;
  logic [1:0]  psel;
  logic [3:0]  alu, dphm, src, dst;
  logic        asel, rpdec;
  logic [1:0]  dpl;
  logic [15:0] idb, p, q, r, ldv, ramw;
  logic [5:0]  fl, fo;
  logic        c, ov0, ov1, s0, s1, vflag, t;
  logic [8:0]  br;
  logic [13:0] jp;
  logic [3:0]  k6;
  logic [3:0]  ldst;
  logic        do_ld;
  logic [10:0] d;
  logic signed [31:0] prod;

  always_comb begin
    op   = s1_r.instruction;
    kind = kind_t'(op[23:22]);
    pcm  = rev_r ? 14'h3fff : 14'h07ff;
    dpm  = rev_r ? 11'h7ff : 11'h0ff;
    rpm  = rev_r ? 11'h7ff : 11'h3ff;
    pc_inc = (pc_r + 14'd1) & pcm;
    psel = op[21:20]; alu = op[19:16]; asel = op[15]; dpl = op[14:13];
    dphm = op[12:9]; rpdec = op[8]; src = op[7:4]; dst = op[3:0];

    pc_nxt = pc_r; sp_nxt = sp_r; dp_nxt = dp_r; rp_nxt = rp_r;
    acca_nxt = acca_r; accb_nxt = accb_r; fla_nxt = fla_r; flb_nxt = flb_r;
    k_nxt = k_r; l_nxt = l_r; tr_nxt = tr_r; trb_nxt = trb_r;
    sr_nxt = sr_r; dr_nxt = dr_r; so_nxt = so_r;
    stk_we = 1'b0; rd_byte = 8'h00; wait_f = 1'b0;
    wr = '0;
    idb = 16'h0; p = 16'h0; q = 16'h0; r = 16'h0; fl = 6'h0; fo = 6'h0;
    c = 1'b0; ov0 = 1'b0; ov1 = 1'b0; s0 = 1'b0; s1 = 1'b0;
    br = op[21:13]; jp = {pc_inc[13], op[1:0], op[12:2]};
    k6 = 4'h0; vflag = 1'b0; t = 1'b0; ldv = 16'h0; ldst = 4'h0; do_ld = 1'b0;
    d = dp_r; ramw = 16'h0;

    case (cmd_t'(s1_r.command))
      CMD_EXEC: begin
        pc_nxt = pc_inc;
        if (kind == KIND_OP || kind == KIND_RT) begin
          case (src)
            4'd0: idb = trb_r;
            4'd1: idb = acca_r;
            4'd2: idb = accb_r;
            4'd3: idb = tr_r;
            4'd4: idb = {5'h0, dp_r};
            4'd5: idb = {5'h0, rp_r};
            4'd6: idb = s1_r.rom_word;
            4'd7: idb = fla_r[F_S1] ? 16'h7fff : 16'h8000;
            4'd8: begin idb = dr_r; sr_nxt = sr_nxt | SR_RQM; end
            4'd9: idb = dr_r;
            4'd10: idb = sr_r;
            4'd13: idb = k_r;
            4'd14: idb = l_r;
            4'd15: idb = rd0;
            default: idb = 16'h0;
          endcase
          if (alu != 4'd0) begin
            case (psel)
              2'd0: p = rd0;
              2'd1: p = idb;
              2'd2: p = m_r;
              default: p = n_r;
            endcase
            q  = asel ? accb_r : acca_r;
            fl = asel ? flb_r : fla_r;
            c  = asel ? fla_r[F_C] : flb_r[F_C];
            case (alu)
              4'd1: r = q | p;
              4'd2: r = q & p;
              4'd3: r = q ^ p;
              4'd4: r = q - p;
              4'd5: r = q + p;
              4'd6: r = q - p - {15'h0, c};
              4'd7: r = q + p + {15'h0, c};
              4'd8: begin r = q - 16'd1; p = 16'd1; end
              4'd9: begin r = q + 16'd1; p = 16'd1; end
              4'd10: r = ~q;
              4'd11: r = {q[15], q[15:1]};
              4'd12: r = {q[14:0], c};
              4'd13: r = {q[13:0], 2'b11};
              4'd14: r = {q[11:0], 4'hf};
              default: r = {q[7:0], q[15:8]};
            endcase
            s0 = r[15];
            ov1 = fl[F_OV1];
            s1 = ov1 ? fl[F_S1] : s0;
            c = 1'b0;
            if (alu >= 4'd4 && alu <= 4'd9) begin
              if (alu[0]) begin
                ov0 = (q[15] ^ r[15]) & ~(q[15] ^ p[15]);
                c = r < q;
              end else begin
                ov0 = (q[15] ^ r[15]) & (q[15] ^ p[15]);
                c = r > q;
              end
              ov1 = (ov0 && ov1) ? (s0 == s1) : (ov0 || ov1);
            end else begin
              ov1 = 1'b0;
              if (alu == 4'd11) c = q[0];
              else if (alu == 4'd12) c = q[15];
            end
            fo = {s1, s0, c, (r == 16'h0), ov1, ov0};
            if (asel) begin accb_nxt = r; flb_nxt = fo; end
            else begin acca_nxt = r; fla_nxt = fo; end
          end
          ldv = idb; ldst = dst; do_ld = 1'b1;
        end else if (kind == KIND_LD) begin
          ldv = op[21:6]; ldst = dst; do_ld = 1'b1;
        end

        if (do_ld) begin
          case (ldst)
            4'd1: acca_nxt = ldv;
            4'd2: accb_nxt = ldv;
            4'd3: tr_nxt = ldv;
            4'd4: dp_nxt = ldv[10:0] & dpm;
            4'd5: rp_nxt = ldv[10:0] & rpm;
            4'd6: begin dr_nxt = ldv; sr_nxt = sr_nxt | SR_RQM; end
            4'd7: sr_nxt = ((sr_nxt & SR_KEEP) | (ldv & ~SR_KEEP)) & SR_BITS;
            4'd8, 4'd9: so_nxt = ldv;
            4'd10: k_nxt = ldv;
            4'd11: begin k_nxt = ldv; l_nxt = s1_r.rom_word; end
            4'd12: begin l_nxt = ldv; k_nxt = rd1; end
            4'd13: l_nxt = ldv;
            4'd14: trb_nxt = ldv;
            4'd15: begin wr.we = 1'b1; wr.waddr = dp_r; wr.wdata = ldv; end
            default: ;
          endcase
        end

        if (kind == KIND_OP || kind == KIND_RT) begin
          if (dst != 4'd4) begin
            d = dp_r;
            // a low-nibble step keeps only bits 7..4 of the high part
            case (dpl)
              2'd1: d = {3'h0, d[7:4], d[3:0] + 4'd1};
              2'd2: d = {3'h0, d[7:4], d[3:0] - 4'd1};
              2'd3: d = {3'h0, d[7:4], 4'h0};
              default: ;
            endcase
            d = d & dpm;
            d = d ^ {3'h0, dphm, 4'h0};
            dp_nxt = d & dpm;
          end
          if (dst != 4'd5 && rpdec) rp_nxt = (rp_r - 11'd1) & rpm;
          if (kind == KIND_RT) begin
            sp_nxt = sp_r - 4'd1;
            pc_nxt = stk_r[sp_nxt];
          end
        end

        if (kind == KIND_JP) begin
          if (br >= 9'h080 && br <= 9'h0af && !br[0]) begin
            k6 = br[4:1];
            fl = k6[1] ? flb_r : fla_r;
            case (br[6:3])
              4'd0, 4'd6: vflag = fl[F_C];
              4'd1, 4'd7: vflag = fl[F_Z];
              4'd2, 4'd8: vflag = fl[F_OV0];
              4'd3, 4'd9: vflag = fl[F_OV1];
              4'd4, 4'd10: vflag = fl[F_S0];
              default: vflag = fl[F_S1];
            endcase
            t = k6[0] ? vflag : !vflag;
            if (t) pc_nxt = jp;
          end else begin
            case (br)
              BR_SO:    pc_nxt = so_r[13:0];
              BR_DPL0:  t = dp_r[3:0] == 4'h0;
              BR_DPLN0: t = dp_r[3:0] != 4'h0;
              BR_DPLF:  t = dp_r[3:0] == 4'hf;
              BR_DPLNF: t = dp_r[3:0] != 4'hf;
              BR_NRQM:  t = !sr_r[15];
              BR_RQM:   t = sr_r[15];
              BR_JMP0:  pc_nxt = {1'b0, jp[12:0]};
              BR_JMP1:  pc_nxt = {1'b1, jp[12:0]};
              BR_CALL0, BR_CALL1: begin
                stk_we = 1'b1;
                sp_nxt = sp_r + 4'd1;
                pc_nxt = {br[0], jp[12:0]};
              end
              default: ;
            endcase
            if (t) pc_nxt = jp;
          end
        end
        pc_nxt = pc_nxt & pcm;
        wait_f = (kind == KIND_JP) && (br == BR_RQM) && ({3'h0, op[12:2]} == pc_nxt);
      end
      CMD_STATUS: rd_byte = sr_r[15:8];
      CMD_DATA_RD: begin
        if (!sr_r[10]) begin
          if (!sr_r[12]) begin
            sr_nxt = sr_r | SR_DRS; rd_byte = dr_r[7:0];
          end else begin
            sr_nxt = sr_r & ~(SR_RQM | SR_DRS); rd_byte = dr_r[15:8];
          end
        end else begin
          sr_nxt = sr_r & ~(SR_RQM | SR_DRS); rd_byte = dr_r[7:0];
        end
      end
      CMD_DATA_WR: begin
        if (!sr_r[10] && sr_r[12]) begin
          sr_nxt = sr_r & ~(SR_RQM | SR_DRS);
          dr_nxt = {s1_r.bus_byte, dr_r[7:0]};
        end else begin
          if (!sr_r[10]) sr_nxt = sr_r | SR_DRS;
          else sr_nxt = sr_r & ~(SR_RQM | SR_DRS);
          dr_nxt = {dr_r[15:8], s1_r.bus_byte};
        end
      end
      CMD_RAM_RD: rd_byte = s1_r.ram_byte_address[0] ? rd0[15:8] : rd0[7:0];
      CMD_RAM_WR: begin
        ramw = s1_r.ram_byte_address[0] ? {s1_r.bus_byte, rd0[7:0]}
                                         : {rd0[15:8], s1_r.bus_byte};
        wr.we = 1'b1;
        wr.waddr = s1_r.ram_byte_address[11:1];
        wr.wdata = ramw;
      end
      default: ;
    endcase
    if (!advance) begin
      wr.we = 1'b0;
      dp_nxt = dp_r;
    end
  end

  // product of the registers after this step
  assign prod = $signed(k_nxt) * $signed(l_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; sp_r <= '0; dp_r <= '0; rp_r <= '0;
      acca_r <= '0; accb_r <= '0; fla_r <= '0; flb_r <= '0;
      k_r <= '0; l_r <= '0; m_r <= '0; n_r <= '0; tr_r <= '0; trb_r <= '0;
      sr_r <= '0; dr_r <= '0; so_r <= '0;
      for (int i = 0; i < StackDepth; i++) stk_r[i] <= '0;
    end else if (advance) begin
      pc_r <= pc_nxt; sp_r <= sp_nxt; dp_r <= dp_nxt; rp_r <= rp_nxt;
      acca_r <= acca_nxt; accb_r <= accb_nxt; fla_r <= fla_nxt; flb_r <= flb_nxt;
      k_r <= k_nxt; l_r <= l_nxt; tr_r <= tr_nxt; trb_r <= trb_nxt;
      sr_r <= sr_nxt; dr_r <= dr_nxt; so_r <= so_nxt;
      if (s1_r.command == CMD_EXEC) begin
        m_r <= prod[30:15];
        n_r <= {prod[14:0], 1'b0};
      end
      // push the address of the word after the call
      if (stk_we) stk_r[sp_r] <= pc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.read_byte        <= rd_byte;
      out_r.next_pc          <= pc_nxt;
      out_r.rom_pointer      <= rp_nxt;
      out_r.waiting_for_host <= wait_f;
    end
  end
endmodule

### hw/rtl/fpdsp_checker.sv
`timescale 1ns / 1ps
module fpdsp_checker import fpdsp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input side is never blocked when nothing is queued
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // an accepted word passes the input and output registers when the output is free
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid ##1 1'b1 |=> out_valid)
    else $error("result missing");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind fixed_point_dsp_instruction_core fpdsp_checker u_fpdsp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);

### sim/tb_fixed_point_dsp_instruction_core.sv
`timescale 1ns / 1ps
module tb_fixed_point_dsp_instruction_core;
  import fpdsp_pkg::*;

  localparam int ALU_NOP = 0, ALU_OR = 1, ALU_AND = 2, ALU_XOR = 3, ALU_SUB = 4, ALU_ADD = 5;
  localparam int ALU_SBB = 6, ALU_ADC = 7, ALU_DEC = 8, ALU_INC = 9, ALU_NOT = 10;
  localparam int ALU_SAR1 = 11, ALU_SHL1 = 12, ALU_SHL2 = 13, ALU_SHL4 = 14, ALU_XCHG = 15;

  localparam int SRC_TRB = 0, SRC_A = 1, SRC_B = 2, SRC_TR = 3, SRC_DP = 4, SRC_RP = 5;
  localparam int SRC_RO = 6, SRC_SGN = 7, SRC_DR = 8, SRC_DRNF = 9, SRC_SR = 10;
  localparam int SRC_SIM = 11, SRC_SIL = 12, SRC_K = 13, SRC_L = 14, SRC_MEM = 15;

  localparam int DST_NON = 0, DST_A = 1, DST_B = 2, DST_TR = 3, DST_DP = 4, DST_RP = 5;
  localparam int DST_DR = 6, DST_SR = 7, DST_SOL = 8, DST_SOM = 9, DST_K = 10;
  localparam int DST_KLR = 11, DST_KLM = 12, DST_L = 13, DST_TRB = 14, DST_MEM = 15;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  fixed_point_dsp_instruction_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        mismatches = 0;
  bit        quiet = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  // shadow of the core's architectural state
  int unsigned rev, pc, stk[16], sp, dp, rp, acc_a, acc_b, fa, fb;
  int unsigned mk, ml, pm, pn, tr, trb, sr, dr, so;
  logic [15:0] ram[2048];
  bit          byte_ok[4096];

  function automatic int unsigned pc_mask();
    return rev ? 32'h3fff : 32'h7ff;
  endfunction
  function automatic int unsigned dp_mask();
    return rev ? 32'h7ff : 32'hff;
  endfunction
  function automatic int unsigned rp_mask();
    return rev ? 32'h7ff : 32'h3ff;
  endfunction

  function automatic void ram_put(int unsigned wi, int unsigned v);
    wi = wi % 2048;
    ram[wi] = v[15:0];
    byte_ok[2 * wi] = 1'b1;
    byte_ok[2 * wi + 1] = 1'b1;
  endfunction

  function automatic void reg_load(int unsigned id, int unsigned dst, int unsigned rom);
    id &= 32'hffff;
    case (dst)
      DST_A:   acc_a = id;
      DST_B:   acc_b = id;
      DST_TR:  tr = id;
      DST_DP:  dp = id & dp_mask();
      DST_RP:  rp = id & rp_mask();
      DST_DR:  begin
        dr = id;
        sr |= SR_RQM;
      end
      DST_SR:  sr = ((sr & SR_KEEP) | (id & ~{16'h0, SR_KEEP})) & SR_BITS;
      DST_SOL, DST_SOM: so = id;
      DST_K:   mk = id;
      DST_KLR: begin
        mk = id;
        ml = rom;
      end
      DST_KLM: begin
        ml = id;
        mk = ram[(dp | 32'h40) % 2048];
      end
      DST_L:   ml = id;
      DST_TRB: trb = id;
      DST_MEM: ram_put(dp, id);
      default: ;
    endcase
  endfunction

  function automatic void alu_exec(int unsigned alu, int unsigned psel, int unsigned asel,
                                   int unsigned idb);
    int unsigned p, q, r, fl, c;
    bit ov0, ov1, s0, s1;
    case (psel)
      0: p = ram[dp % 2048];
      1: p = idb;
      2: p = pm;
      default: p = pn;
    endcase
    if (asel == 0) begin
      q = acc_a; fl = fa; c = (fb >> F_C) & 1;
    end else begin
      q = acc_b; fl = fb; c = (fa >> F_C) & 1;
    end
    case (alu)
      ALU_OR:   r = q | p;
      ALU_AND:  r = q & p;
      ALU_XOR:  r = q ^ p;
      ALU_SUB:  r = q - p;
      ALU_ADD:  r = q + p;
      ALU_SBB:  r = q - p - c;
      ALU_ADC:  r = q + p + c;
      ALU_DEC:  begin r = q - 1; p = 1; end
      ALU_INC:  begin r = q + 1; p = 1; end
      ALU_NOT:  r = ~q;
      ALU_SAR1: r = (q >> 1) | (q & 32'h8000);
      ALU_SHL1: r = (q << 1) | c;
      ALU_SHL2: r = (q << 2) | 3;
      ALU_SHL4: r = (q << 4) | 15;
      default:  r = (q << 8) | (q >> 8);
    endcase
    r &= 32'hffff;
    s0 = r[15];
    ov1 = fl[F_OV1];
    s1 = ov1 ? fl[F_S1] : s0;
    ov0 = 1'b0;
    c = 0;
    if (alu >= ALU_SUB && alu <= ALU_INC) begin
      if (alu & 1) begin
        ov0 = (((q ^ r) & ~(q ^ p)) >> 15) & 1;
        c = (r < q);
      end else begin
        ov0 = (((q ^ r) & (q ^ p)) >> 15) & 1;
        c = (r > q);
      end
      ov1 = (ov0 && ov1) ? (s0 == s1) : (ov0 || ov1);
    end else begin
      ov1 = 1'b0;
      if (alu == ALU_SAR1) c = q & 1;
      else if (alu == ALU_SHL1) c = (q >> 15) & 1;
    end
    fl = (s1 << F_S1) | (s0 << F_S0) | ((c != 0) << F_C) | ((r == 0) << F_Z) |
         (ov1 << F_OV1) | (ov0 << F_OV0);
    if (asel == 0) begin
      acc_a = r; fa = fl;
    end else begin
      acc_b = r; fb = fl;
    end
  endfunction

  function automatic void op_exec(int unsigned op, int unsigned rom);
    int unsigned alu, src, dst, dpl, dphm, idb, d;
    alu = (op >> 16) & 15;
    dpl = (op >> 13) & 3;
    dphm = (op >> 9) & 15;
    src = (op >> 4) & 15;
    dst = op & 15;
    case (src)
      SRC_TRB:  idb = trb;
      SRC_A:    idb = acc_a;
      SRC_B:    idb = acc_b;
      SRC_TR:   idb = tr;
      SRC_DP:   idb = dp;
      SRC_RP:   idb = rp;
      SRC_RO:   idb = rom;
      SRC_SGN:  idb = (32'h8000 - ((fa >> F_S1) & 1)) & 32'hffff;
      SRC_DR:   begin
        idb = dr;
        sr |= SR_RQM;
      end
      SRC_DRNF: idb = dr;
      SRC_SR:   idb = sr;
      SRC_K:    idb = mk;
      SRC_L:    idb = ml;
      SRC_MEM:  idb = ram[dp % 2048];
      default:  idb = 0;
    endcase
    if (alu != ALU_NOP) alu_exec(alu, (op >> 20) & 3, (op >> 15) & 1, idb);
    reg_load(idb, dst, rom);
    if (dst != DST_DP) begin
      d = dp;
      if (dpl == 1) d = (d & 32'hf0) + ((d + 1) & 32'h0f);
      else if (dpl == 2) d = (d & 32'hf0) + ((d - 1) & 32'h0f);
      else if (dpl == 3) d = d & 32'hf0;
      d &= dp_mask();
      d ^= dphm << 4;
      dp = d & dp_mask();
    end
    if (dst != DST_RP && ((op >> 8) & 1)) rp = (rp - 1) & rp_mask();
  endfunction

  function automatic void jump_exec(int unsigned op);
    int unsigned br, jp, dl, k, fl, bitpos;
    bit taken;
    int unsigned flag_pos[6];
    flag_pos = '{F_C, F_Z, F_OV0, F_OV1, F_S0, F_S1};
    br = (op >> 13) & 32'h1ff;
    jp = ((pc & 32'h2000) | ((op & 3) << 11) | ((op >> 2) & 32'h7ff)) & 32'h3fff;
    dl = dp & 32'h0f;
    taken = 1'b0;
    if (br >= 32'h080 && br <= 32'h0af && (br & 1) == 0) begin
      k = (br - 32'h080) >> 1;
      fl = (k & 2) ? fb : fa;
      bitpos = flag_pos[(k >> 2) % 6];
      taken = (k & 1) ? fl[bitpos] : !fl[bitpos];
    end else begin
      case (br[8:0])
        BR_SO:    begin pc = so & pc_mask(); return; end
        BR_DPL0:  taken = (dl == 0);
        BR_DPLN0: taken = (dl != 0);
        BR_DPLF:  taken = (dl == 15);
        BR_DPLNF: taken = (dl != 15);
        BR_NRQM:  taken = (sr & SR_RQM) == 0;
        BR_RQM:   taken = (sr & SR_RQM) != 0;
        BR_JMP0:  begin pc = jp & ~32'h2000; return; end
        BR_JMP1:  begin pc = jp | 32'h2000; return; end
        BR_CALL0, BR_CALL1: begin
          stk[sp] = pc;
          sp = (sp + 1) & 15;
          pc = (br & 1) ? (jp | 32'h2000) : (jp & ~32'h2000);
          return;
        end
        default: ;
      endcase
    end
    if (taken) pc = jp;
  endfunction

  function automatic out_word_t dsp_step(in_word_t w);
    out_word_t res;
    int unsigned op, kind, rd, wi, word;
    int sk, sl, prod;
    op = w.instruction;
    rd = 0;
    res = '0;
    case (w.command)
      CMD_EXEC: begin
        kind = op >> 22;
        pc = (pc + 1) & pc_mask();
        if (kind == KIND_OP) op_exec(op, w.rom_word);
        else if (kind == KIND_RT) begin
          op_exec(op, w.rom_word);
          sp = (sp - 1) & 15;
          pc = stk[sp];
        end else if (kind == KIND_JP) jump_exec(op);
        else reg_load(op >> 6, op & 15, w.rom_word);
        pc &= pc_mask();
        sk = $signed(mk[15:0]);
        sl = $signed(ml[15:0]);
        prod = sk * sl;
        pm = (prod >>> 15) & 32'hffff;
        pn = (prod << 1) & 32'hffff;
        res.waiting_for_host = (kind == KIND_JP) && (((op >> 13) & 32'h1ff) == BR_RQM) &&
                               (((op >> 2) & 32'h7ff) == pc);
      end
      CMD_STATUS: rd = (sr >> 8) & 32'hff;
      CMD_DATA_RD: begin
        if ((sr & SR_DRC) == 0) begin
          if ((sr & SR_DRS) == 0) begin
            sr |= SR_DRS;
            rd = dr & 32'hff;
          end else begin
            sr &= ~{16'h0, SR_RQM | SR_DRS};
            rd = (dr >> 8) & 32'hff;
          end
        end else begin
          sr &= ~{16'h0, SR_RQM | SR_DRS};
          rd = dr & 32'hff;
        end
      end
      CMD_DATA_WR: begin
        if ((sr & SR_DRC) == 0 && (sr & SR_DRS) != 0) begin
          sr &= ~{16'h0, SR_RQM | SR_DRS};
          dr = (w.bus_byte << 8) | (dr & 32'hff);
        end else begin
          if ((sr & SR_DRC) == 0) sr |= SR_DRS;
          else sr &= ~{16'h0, SR_RQM | SR_DRS};
          dr = (dr & 32'hff00) | w.bus_byte;
        end
      end
      CMD_RAM_RD: begin
        word = ram[(w.ram_byte_address >> 1) % 2048];
        rd = w.ram_byte_address[0] ? (word >> 8) & 32'hff : word & 32'hff;
      end
      CMD_RAM_WR: begin
        wi = (w.ram_byte_address >> 1) % 2048;
        if (w.ram_byte_address[0]) ram[wi][15:8] = w.bus_byte;
        else ram[wi][7:0] = w.bus_byte;
        byte_ok[2 * wi + w.ram_byte_address[0]] = 1'b1;
      end
      default: ;
    endcase
    res.read_byte = rd[7:0];
    res.next_pc = pc[13:0];
    res.rom_pointer = rp[10:0];
    return res;
  endfunction

  function automatic int word_gap(int unsigned wi);
    wi = wi % 2048;
    if (!byte_ok[2 * wi]) return 2 * wi;
    if (!byte_ok[2 * wi + 1]) return 2 * wi + 1;
    return -1;
  endfunction

  // first RAM byte that the word would read before anything wrote it, else -1
  function automatic int unwritten_read(in_word_t w);
    int unsigned op, kind, dst, alu, src;
    int g;
    op = w.instruction;
    kind = op >> 22;
    dst = op & 15;
    alu = (op >> 16) & 15;
    src = (op >> 4) & 15;
    g = -1;
    if (w.command == CMD_RAM_RD) begin
      if (!byte_ok[w.ram_byte_address]) g = w.ram_byte_address;
    end else if (w.command == CMD_EXEC) begin
      if (kind == KIND_OP || kind == KIND_RT) begin
        if (src == SRC_MEM || (alu != ALU_NOP && ((op >> 20) & 3) == 0)) g = word_gap(dp);
        if (g < 0 && dst == DST_KLM) g = word_gap(dp | 32'h40);
      end else if (kind == KIND_LD && dst == DST_KLM) g = word_gap(dp | 32'h40);
    end
    return g;
  endfunction

  task automatic post_word(in_word_t w);
    in_word_t fill;
    int g;
    g = unwritten_read(w);
    while (g >= 0) begin
      fill = '0;
      fill.command = CMD_RAM_WR;
      fill.bus_byte = 8'($urandom);
      fill.ram_byte_address = 12'(g);
      pending_words.push_back(fill);
      expected_words.push_back(dsp_step(fill));
      g = unwritten_read(w);
    end
    pending_words.push_back(w);
    expected_words.push_back(dsp_step(w));
  endtask

  function automatic in_word_t make_word(logic [2:0] cmd, logic [23:0] op);
    in_word_t w;
    w.command = cmd;
    w.instruction = op;
    w.rom_word = 16'($urandom);
    w.bus_byte = 8'($urandom);
    w.ram_byte_address = 12'($urandom);
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int unsigned sel, br, na;
    logic [8:0] brs[12];
    brs = '{BR_SO, BR_DPL0, BR_DPLN0, BR_DPLF, BR_DPLNF, BR_NRQM, BR_RQM,
            BR_JMP0, BR_JMP1, BR_CALL0, BR_CALL1, 9'h0b4};
    w = make_word(CMD_EXEC, 24'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 62) begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1)) br = 32'h080 + 2 * $urandom_range(0, 23);
        else br = brs[$urandom_range(0, 11)];
        if ($urandom_range(0, 9) == 0) br = $urandom_range(0, 511);
        w.instruction[23:22] = KIND_JP;
        w.instruction[21:13] = br[8:0];
        if (br == BR_RQM && $urandom_range(0, 1)) begin
          na = $urandom_range(0, 1) ? ((pc + 1) & pc_mask()) : pc;
          w.instruction[12:2] = na[10:0];
          w.instruction[1:0] = 2'd0;
        end
      end
    end else if (sel < 68) w.command = CMD_STATUS;
    else if (sel < 76) w.command = CMD_DATA_RD;
    else if (sel < 84) w.command = CMD_DATA_WR;
    else if (sel < 90) w.command = CMD_RAM_RD;
    else if (sel < 97) w.command = CMD_RAM_WR;
    else w.command = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
    if ($urandom_range(0, 1)) w.ram_byte_address = 12'($urandom_range(0, 63));
    return w;
  endfunction

  task automatic drain();
    wait (expected_words.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_revision(bit v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rev = v;
  endtask

  // feed words, holding off for idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        e = expected_words.pop_front();
        if (out_data.read_byte !== e.read_byte || out_data.next_pc !== e.next_pc ||
            out_data.rom_pointer !== e.rom_pointer ||
            out_data.waiting_for_host !== e.waiting_for_host) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: byte %h/%h pc %h/%h rp %h/%h wait %b/%b (exp/got)",
                     e.read_byte, out_data.read_byte, e.next_pc, out_data.next_pc,
                     e.rom_pointer, out_data.rom_pointer,
                     e.waiting_for_host, out_data.waiting_for_host);
        end
      end
    end
  end

  initial begin
    int unsigned i, ph;
    rev = 0; pc = 0; sp = 0; dp = 0; rp = 0; acc_a = 0; acc_b = 0; fa = 0; fb = 0;
    mk = 0; ml = 0; pm = 0; pn = 0; tr = 0; trb = 0; sr = 0; dr = 0; so = 0;
    for (i = 0; i < 16; i++) stk[i] = 0;
    for (i = 0; i < 4096; i++) byte_ok[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_revision(1'b0);

    // directed: host port, extremes, each ALU op, jumps and returns
    post_word(make_word(CMD_RSVD6, 24'h0));
    post_word(make_word(CMD_RSVD7, 24'hffffff));
    post_word(make_word(CMD_EXEC, 24'hffffff));
    post_word(make_word(CMD_EXEC, 24'hc0_0006));
    post_word(make_word(CMD_STATUS, 24'h0));
    post_word(make_word(CMD_DATA_RD, 24'h0));
    post_word(make_word(CMD_DATA_RD, 24'h0));
    post_word(make_word(CMD_DATA_WR, 24'h0));
    post_word(make_word(CMD_DATA_WR, 24'h0));
    post_word(make_word(CMD_RAM_WR, 24'h0));
    post_word(make_word(CMD_RAM_RD, 24'h0));
    for (i = 1; i < 16; i++)
      post_word(make_word(CMD_EXEC, {2'(KIND_OP), 2'd1, 4'(i), 1'(i & 1), 15'h0161}));
    post_word(make_word(CMD_EXEC, {2'(KIND_JP), BR_CALL1, 13'h1fff}));
    post_word(make_word(CMD_EXEC, {2'(KIND_RT), 22'h0}));
    post_word(make_word(CMD_EXEC, {2'(KIND_JP), BR_SO, 13'h0}));
    drain();

    for (ph = 0; ph < 4; ph++) begin
      set_revision(ph % 2 == 0);
      if (ph == 3) quiet = 1'b1;
      for (i = 0; i < 175; i++) post_word(random_word());
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("[fixed_point_dsp_instruction_core] OK");
    else
      $display("[fixed_point_dsp_instruction_core] ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[fixed_point_dsp_instruction_core] ERROR");
    $finish;
  end

endmodule
